/* design/gf64rma_pkg.sv */
`default_nettype none

package gf64rma_pkg;

   localparam int ELEM_W     = 64;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int CHUNK_W    = 16;
   localparam int NCHUNK     = ELEM_W / CHUNK_W;
   localparam int PART_W     = ELEM_W + CHUNK_W;
   localparam int LANES      = 2;
   localparam int MAX_COEFFS = 4;
   localparam int CSR_COEFFS = 4;
   localparam int MODE_W     = 1;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_BASE = 3'd2;

   localparam logic [MODE_W-1:0]  MODE_WRITE  = 1'b0;
   localparam logic [MODE_W-1:0]  MODE_ACCUM  = 1'b1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
   } pipe_ctl_type;

endpackage

`default_nettype wire

/* design/gf64rma_clmul.sv */
`default_nettype none

module gf64rma_clmul (
   input  wire logic                                clock,
   input  wire gf64rma_pkg::pipe_ctl_type           ctl,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]      elem,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]      coeff,
   output logic      [gf64rma_pkg::PROD_W-1:0]      prod
);

   logic [gf64rma_pkg::PART_W-1:0] part_ff [gf64rma_pkg::NCHUNK];
   logic [gf64rma_pkg::PART_W-1:0] part_in [gf64rma_pkg::NCHUNK];
   logic [gf64rma_pkg::PROD_W-1:0] prod_ff;
   logic [gf64rma_pkg::PROD_W-1:0] prod_in;

   function automatic logic [gf64rma_pkg::PART_W-1:0] clmul_chunk(
      input logic [gf64rma_pkg::ELEM_W-1:0]  a,
      input logic [gf64rma_pkg::CHUNK_W-1:0] b
   );
      logic [gf64rma_pkg::PART_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < gf64rma_pkg::CHUNK_W; i++) begin
         if (b[i]) begin
            acc = acc ^ (gf64rma_pkg::PART_W'(a) << i);
         end
      end
      return acc;
   endfunction

   always_comb begin
      for (int j = 0; j < gf64rma_pkg::NCHUNK; j++) begin
         part_in[j] = clmul_chunk(elem, coeff[j*gf64rma_pkg::CHUNK_W +: gf64rma_pkg::CHUNK_W]);
      end
   end

   always_comb begin
      prod_in = '0;
      for (int j = 0; j < gf64rma_pkg::NCHUNK; j++) begin
         prod_in = prod_in ^ (gf64rma_pkg::PROD_W'(part_ff[j]) << (j * gf64rma_pkg::CHUNK_W));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         part_ff <= part_in;
      end
      if (ctl.load_s2) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* design/gf64rma_merge.sv */
`default_nettype none

module gf64rma_merge #(
   parameter int NUM_COEFF = gf64rma_pkg::CSR_COEFFS
) (
   input  wire logic                                        clock,
   input  wire logic                                        load,
   input  wire logic [gf64rma_pkg::MODE_W-1:0]              mode,
   input  wire logic                                        lane_valid,
   input  wire logic [NUM_COEFF-1:0]                        active,
   input  wire logic [NUM_COEFF-1:0][gf64rma_pkg::PROD_W-1:0] prod,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]              prior,
   output logic      [gf64rma_pkg::ELEM_W-1:0]              result
);

   logic [gf64rma_pkg::PROD_W-1:0] sum;
   logic [gf64rma_pkg::ELEM_W-1:0] reduced;
   logic [gf64rma_pkg::ELEM_W-1:0] result_ff;
   logic [gf64rma_pkg::ELEM_W-1:0] result_in;

   // Reduction modulo x^64 + x^4 + x^3 + x + 1 in two folding rounds.
   function automatic logic [gf64rma_pkg::ELEM_W-1:0] reduce128(
      input logic [gf64rma_pkg::PROD_W-1:0] p
   );
      logic [gf64rma_pkg::ELEM_W-1:0] lo;
      logic [gf64rma_pkg::ELEM_W-1:0] hi;
      logic [gf64rma_pkg::ELEM_W-1:0] fold;
      logic [gf64rma_pkg::ELEM_W-1:0] over;
      logic [gf64rma_pkg::ELEM_W-1:0] fold2;
      lo    = p[gf64rma_pkg::ELEM_W-1:0];
      hi    = p[gf64rma_pkg::PROD_W-1:gf64rma_pkg::ELEM_W];
      fold  = (hi << 4) ^ (hi << 3) ^ (hi << 1) ^ hi;
      over  = '0;
      over[0] = hi[60] ^ hi[61] ^ hi[63];
      over[1] = hi[61] ^ hi[62];
      over[2] = hi[62] ^ hi[63];
      over[3] = hi[63];
      fold2 = (over << 4) ^ (over << 3) ^ (over << 1) ^ over;
      return lo ^ fold ^ fold2;
   endfunction

   // Reduction is linear, so the coefficient products are summed before it.
   always_comb begin
      sum = '0;
      for (int c = 0; c < NUM_COEFF; c++) begin
         if (active[c]) begin
            sum = sum ^ prod[c];
         end
      end
   end

   assign reduced = reduce128(sum);

   always_comb begin
      if (!lane_valid) begin
         result_in = '0;
      end else if (mode == gf64rma_pkg::MODE_ACCUM) begin
         result_in = prior ^ reduced;
      end else begin
         result_in = reduced;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* design/gf64_region_multiply_accumulate.sv */
`default_nettype none

// An accepted request moves through the partial-product, product and result
// registers to rsp_valid. Throughput: one request per cycle without rsp_stall;
// every lane and coefficient has its own two-stage carryless multiplier,
// followed by one merge and reduction stage. Reset clears the pipeline valid
// bits, sets mode to 0, the coefficient count to 1 and all coefficients to 0.

module gf64_region_multiply_accumulate #(
   parameter int MAX_COEFFS = gf64rma_pkg::MAX_COEFFS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]       req_data_0,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]       req_data_1,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]       req_prior_0,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]       req_prior_1,
   input  wire logic                                 req_lane1_valid,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [gf64rma_pkg::ELEM_W-1:0]       rsp_result_0,
   output logic      [gf64rma_pkg::ELEM_W-1:0]       rsp_result_1,
   input  wire logic                                 csr_wr_en,
   input  wire logic [gf64rma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gf64rma_pkg::ELEM_W-1:0]       csr_wdata
);

   localparam int NUM_COEFF = (MAX_COEFFS < gf64rma_pkg::CSR_COEFFS) ?
                              MAX_COEFFS : gf64rma_pkg::CSR_COEFFS;

   logic [gf64rma_pkg::MODE_W-1:0]  mode_ff;
   logic [gf64rma_pkg::MODE_W-1:0]  mode_in;
   logic [gf64rma_pkg::COUNT_W-1:0] count_ff;
   logic [gf64rma_pkg::COUNT_W-1:0] count_in;
   logic [gf64rma_pkg::ELEM_W-1:0]  coeff_ff [NUM_COEFF];
   logic [gf64rma_pkg::ELEM_W-1:0]  coeff_in [NUM_COEFF];
   logic [NUM_COEFF-1:0]            active;

   logic v1_ff;
   logic v1_in;
   logic v2_ff;
   logic v2_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic ready1;
   logic ready2;
   logic ready3;
   logic load_out;
   gf64rma_pkg::pipe_ctl_type ctl;

   logic [gf64rma_pkg::ELEM_W-1:0] prior_s1_ff [gf64rma_pkg::LANES];
   logic [gf64rma_pkg::ELEM_W-1:0] prior_s2_ff [gf64rma_pkg::LANES];
   logic [gf64rma_pkg::LANES-1:0]  lv_s1_ff;
   logic [gf64rma_pkg::LANES-1:0]  lv_s2_ff;

   logic [gf64rma_pkg::ELEM_W-1:0] data_lane   [gf64rma_pkg::LANES];
   logic [gf64rma_pkg::ELEM_W-1:0] prior_lane  [gf64rma_pkg::LANES];
   logic [gf64rma_pkg::LANES-1:0]  lv_lane;
   logic [gf64rma_pkg::ELEM_W-1:0] result_lane [gf64rma_pkg::LANES];
   logic [NUM_COEFF-1:0][gf64rma_pkg::PROD_W-1:0] prod_lane [gf64rma_pkg::LANES];

   assign data_lane[0]  = req_data_0;
   assign data_lane[1]  = req_data_1;
   assign prior_lane[0] = req_prior_0;
   assign prior_lane[1] = req_prior_1;
   assign lv_lane       = {req_lane1_valid, 1'b1};

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      coeff_in = coeff_ff;
      if (csr_wr_en) begin
         priority if (csr_index == gf64rma_pkg::CSR_MODE) begin
            mode_in = csr_wdata[gf64rma_pkg::MODE_W-1:0];
         end else if (csr_index == gf64rma_pkg::CSR_COUNT) begin
            count_in = csr_wdata[gf64rma_pkg::COUNT_W-1:0];
         end else begin
            for (int c = 0; c < NUM_COEFF; c++) begin
               if (csr_index == gf64rma_pkg::CSR_COEFF_BASE + gf64rma_pkg::CSR_IDX_W'(c)) begin
                  coeff_in[c] = csr_wdata;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= gf64rma_pkg::MODE_WRITE;
         count_ff <= gf64rma_pkg::COUNT_RESET;
         for (int c = 0; c < NUM_COEFF; c++) begin
            coeff_ff[c] <= '0;
         end
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         coeff_ff <= coeff_in;
      end
   end

   // Every stored coefficient sits below the saturation limit, so the count
   // alone decides which ones take part.
   always_comb begin
      for (int c = 0; c < NUM_COEFF; c++) begin
         active[c] = ({1'b0, count_ff} > (gf64rma_pkg::COUNT_W + 1)'(c));
      end
   end

   assign ready3      = !rsp_valid_ff || !rsp_stall;
   assign ready2      = !v2_ff || ready3;
   assign ready1      = !v1_ff || ready2;
   assign req_stall   = !ready1;
   assign ctl.load_s1 = req_valid && ready1;
   assign ctl.load_s2 = v1_ff && ready2;
   assign load_out    = v2_ff && ready3;

   assign v1_in        = ready1 ? req_valid : v1_ff;
   assign v2_in        = ready2 ? v1_ff : v2_ff;
   assign rsp_valid_in = ready3 ? v2_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         prior_s1_ff <= prior_lane;
         lv_s1_ff    <= lv_lane;
      end
      if (ctl.load_s2) begin
         prior_s2_ff <= prior_s1_ff;
         lv_s2_ff    <= lv_s1_ff;
      end
   end

   for (genvar l = 0; l < gf64rma_pkg::LANES; l++) begin : g_lane
      for (genvar c = 0; c < NUM_COEFF; c++) begin : g_coeff
         gf64rma_clmul u_clmul (
            .clock (clock),
            .ctl   (ctl),
            .elem  (data_lane[l]),
            .coeff (coeff_ff[c]),
            .prod  (prod_lane[l][c])
         );
      end

      gf64rma_merge #(
         .NUM_COEFF (NUM_COEFF)
      ) u_merge (
         .clock      (clock),
         .load       (load_out),
         .mode       (mode_ff),
         .lane_valid (lv_s2_ff[l]),
         .active     (active),
         .prod       (prod_lane[l]),
         .prior      (prior_s2_ff[l]),
         .result     (result_lane[l])
      );
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_0 = result_lane[0];
   assign rsp_result_1 = result_lane[1];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request did not enter the first stage");

   a_stage2_held: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !ready3) |=> v2_ff)
      else $error("stalled request was dropped from the second stage");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff && !rsp_valid_ff) |-> !req_stall)
      else $error("empty pipeline refused a request");

   a_lane1_zero: assert property (@(posedge clock) disable iff (reset)
      (load_out && !lv_s2_ff[1]) |=> (rsp_result_1 == '0))
      else $error("absent second element gave a nonzero result");

endmodule

`default_nettype wire
